>>> hw/rtl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, field widths and operation and status codes for the bounded
// deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Default number of entries held by the deque.
  localparam int unsigned DepthDefault = 64;

  // Field widths of the stream payloads.
  localparam int unsigned OpW  = 3;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 2;
  localparam int unsigned PosW = 6;
  localparam int unsigned CntW = 7;

  // Output tdata width, padded to whole bytes.
  localparam int unsigned ResDataW = 16;

  // Operation codes carried on the input tuser.
  localparam logic [OpW-1:0] OpPushFront = 3'd0;
  localparam logic [OpW-1:0] OpPushBack  = 3'd1;
  localparam logic [OpW-1:0] OpPopFront  = 3'd2;
  localparam logic [OpW-1:0] OpPopBack   = 3'd3;
  localparam logic [OpW-1:0] OpClear     = 3'd4;
  localparam logic [OpW-1:0] OpFind      = 3'd5;

  // Status codes carried on the output tuser.
  localparam logic [StW-1:0] StatOk       = 2'd0;
  localparam logic [StW-1:0] StatFull     = 2'd1;
  localparam logic [StW-1:0] StatEmpty    = 2'd2;
  localparam logic [StW-1:0] StatNotFound = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted transaction
    logic scan_start;  // set up a search from the front entry
    logic scan_step;   // advance the search by one entry
    logic commit;      // update the deque and load the result register
  } bdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_find;     // captured operation is a search
    logic is_empty;    // no entries held
    logic scan_done;   // search hit an entry or compared the last one
    logic res_free;    // result register can take a new result
  } bdq_sts_t;

  // One result item.
  typedef struct packed {
    logic [StW-1:0]  status;
    logic            found;
    logic [PosW-1:0] position;
    logic [CntW-1:0] count;
    logic            empty_res;
  } bdq_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/bounded_deque_with_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit values with a linear search.
// ----------------------------------------------------------------------------
// The deque holds up to DEPTH values in a ring memory. Each input transaction
// carries an operation on s_axis_tuser and a value on s_axis_tdata, and
// produces exactly one result transaction. Push, pop, clear, the unused codes
// and a find on an empty deque pass through accept, decode and commit, and
// the result is offered in the cycle after the commit. A find reads the entry
// memory through its single read port, one entry per cycle starting at the
// front, after a step that primes the registered read, and stops at the
// first match. One transaction is processed at a time. The commit waits
// while the output register still holds a result that has not been taken.
// The next transaction is accepted in the cycle after the previous result is
// loaded into the output register, even if that result has not yet been
// taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire [bdq_pkg::ValW-1:0]       s_axis_tdata,  // [31:0] value
  input  wire [bdq_pkg::OpW-1:0]        s_axis_tuser,  // [2:0] op
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [0] found, [6:1] position, [13:7] count, [14] empty_res, [15] zero
  output logic [bdq_pkg::ResDataW-1:0]  m_axis_tdata,
  output logic [bdq_pkg::StW-1:0]       m_axis_tuser   // [1:0] status
);
  import bdq_pkg::*;

  bdq_cmd_t cmd;
  bdq_sts_t sts;
  bdq_res_t res;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {1'b0, res.empty_res, res.count, res.position, res.found};
  assign m_axis_tuser = res.status;

endmodule
`default_nettype wire

>>> hw/rtl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller state machine: accepts one transaction, runs an optional search
// scan, and commits the operation once the result register is free.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  bdq_pkg::bdq_sts_t sts_i,
  output bdq_pkg::bdq_cmd_t cmd_o
);
  import bdq_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDecode = 4'b0010,
    StScan   = 4'b0100,
    StCommit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next-state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.is_find && !sts_i.is_empty) begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end else begin
          state_d = StCommit;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (sts_i.res_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bdq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dpath
// Datapath: entry memory as a ring, head index and count, search pipeline
// and the result register.
// ----------------------------------------------------------------------------
module bdq_dpath #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire [bdq_pkg::OpW-1:0]    op_i,
  input  wire [bdq_pkg::ValW-1:0]   value_i,
  input  bdq_pkg::bdq_cmd_t         cmd_i,
  output bdq_pkg::bdq_sts_t         sts_o,
  output logic                      res_valid_o,
  input  wire                       res_ready_i,
  output bdq_pkg::bdq_res_t         res_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
  localparam logic [SW-1:0] DepthS   = SW'(DEPTH);

  // Captured transaction.
  logic [OpW-1:0]  op_q;
  logic [ValW-1:0] value_q;

  // Ring bookkeeping.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // Search pipeline.
  logic [AW-1:0]   rd_slot_q;
  logic [CW-1:0]   rd_idx_q;
  logic [CW-1:0]   cmp_idx_q;
  logic            cmp_vld_q;
  logic [ValW-1:0] rdata_q;
  logic            hit_q;
  logic [CW-1:0]   pos_q;
  logic            match;

  // Result register.
  bdq_res_t res_q, res_d;
  logic     res_vld_q;

  // Memory write port.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ValW-1:0] mem [DEPTH];

  // Ring slot arithmetic.
  logic [AW-1:0] head_dec, head_inc, back_slot;
  logic [SW-1:0] back_sum;
  logic          is_full;

  assign head_dec  = (head_q == '0) ? LastSlot : head_q - AW'(1);
  assign head_inc  = (head_q == LastSlot) ? '0 : head_q + AW'(1);
  assign back_sum  = SW'(head_q) + SW'(count_q);
  assign back_slot = (back_sum >= DepthS) ? AW'(back_sum - DepthS) : AW'(back_sum);
  assign is_full   = (count_q == FullCnt);

  assign match = (rdata_q == value_q);

  // Status toward the controller.
  assign sts_o.is_find   = (op_q == OpFind);
  assign sts_o.is_empty  = (count_q == '0);
  assign sts_o.scan_done = cmp_vld_q && (match || ((cmp_idx_q + CW'(1)) == count_q));
  assign sts_o.res_free  = !res_vld_q || res_ready_i;

  // Operation effect and result at commit.
  always_comb begin
    head_d          = head_q;
    count_d         = count_q;
    mem_we          = 1'b0;
    mem_waddr       = head_dec;
    res_d.status    = StatOk;
    res_d.found     = 1'b0;
    res_d.position  = '0;
    unique case (op_q)
      OpPushFront: begin
        if (is_full) begin
          res_d.status = StatFull;
        end else begin
          head_d  = head_dec;
          count_d = count_q + CW'(1);
          mem_we  = 1'b1;
        end
      end
      OpPushBack: begin
        mem_waddr = back_slot;
        if (is_full) begin
          res_d.status = StatFull;
        end else begin
          count_d = count_q + CW'(1);
          mem_we  = 1'b1;
        end
      end
      OpPopFront: begin
        if (count_q == '0) begin
          res_d.status = StatEmpty;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
      end
      OpPopBack: begin
        if (count_q == '0) begin
          res_d.status = StatEmpty;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      OpClear: begin
        head_d  = '0;
        count_d = '0;
      end
      OpFind: begin
        res_d.status   = hit_q ? StatOk : StatNotFound;
        res_d.found    = hit_q;
        res_d.position = PosW'(pos_q);
      end
      default: begin
        res_d.status = StatOk;
      end
    endcase
    res_d.count     = CntW'(count_d);
    res_d.empty_res = (count_d == '0);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      res_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      // A commit only happens when the register is free, so it wins.
      if (cmd_i.commit) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= (rd_idx_q < count_q);
      end
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.scan_step && cmp_vld_q && match && !hit_q) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      value_q <= value_i;
      pos_q   <= '0;
    end else if (cmd_i.scan_step && cmp_vld_q && match && !hit_q) begin
      pos_q <= cmp_idx_q;
    end
    if (cmd_i.scan_start) begin
      rd_slot_q <= head_q;
      rd_idx_q  <= '0;
    end else if (cmd_i.scan_step) begin
      rd_slot_q <= (rd_slot_q == LastSlot) ? '0 : rd_slot_q + AW'(1);
      rd_idx_q  <= rd_idx_q + CW'(1);
      cmp_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem[mem_waddr] <= value_q;
    end
    rdata_q <= mem[rd_slot_q];
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
